FILE: sv/swrm_pkg.sv
// ----------------------------------------------------------------------------
// Stack with remove-minimum: shared definitions
// Sizes, request and status codes, and the transfer types of the block.
// ----------------------------------------------------------------------------
package swrm_pkg;

  localparam int unsigned DEPTH   = 8;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned ECNT_W  = 4;

  localparam logic [REQ_W-1:0] REQ_PUSH       = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP        = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE_MIN = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic signed [DATA_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] removed_value;
    logic signed [DATA_W-1:0] top_value;
    logic                     is_empty;
    logic [ECNT_W-1:0]        entry_count;
  } out_item_t;

  // One write port and one registered read port of the entry store.
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

endpackage

FILE: sv/swrm_store.sv
// ----------------------------------------------------------------------------
// Stack with remove-minimum: entry store
// Holds the stack entries; one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module swrm_store (
  input  logic                          clk_i,
  input  swrm_pkg::mem_req_t            req_i,
  output logic [swrm_pkg::DATA_W-1:0]   rdata_o
);

  logic [swrm_pkg::DATA_W-1:0] mem [swrm_pkg::DEPTH];
  logic [swrm_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/stack_with_remove_min_top.sv
// ----------------------------------------------------------------------------
// Stack with remove-minimum: top level
// Bounded stack of signed words with push, pop and remove-minimum requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid_i/in_data_i and are taken when in_stall_o is
//   low; the block takes one request at a time and holds in_stall_o high
//   until the request's result is loaded into the output register.
//   Every request yields exactly one result on out_valid_o/out_data_o.
//   Push, pop and the unused request code pass through S_TOP and then S_LOAD,
//   where the result is loaded, and the next request can be taken once the block is back in S_IDLE.
//   Remove-minimum walks the stored entries through one read port and one
//   signed comparator, one entry per cycle, then moves the entries above the
//   minimum down one place per cycle; it then passes through S_TOP and
//   S_LOAD like a push, and the next request can be taken once the block
//   is back in S_IDLE. Remove on an empty stack takes as long as a push.
//   The single memory read port sets the pace of the scan and the shift.
//   Reset empties the stack; entry contents are not cleared.
//   While the receiver stalls, the result stays in the output register; the
//   next request may be taken and worked on, but its result waits until the
//   output register has been emptied.
// ----------------------------------------------------------------------------
module stack_with_remove_min_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  swrm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output swrm_pkg::out_item_t out_data_o
);

  localparam int unsigned CW = swrm_pkg::CNT_W;
  localparam int unsigned IW = swrm_pkg::IDX_W;
  localparam int unsigned DW = swrm_pkg::DATA_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_TOP   = 5'b01000,
    S_LOAD  = 5'b10000
  } state_e;

  state_e                        state_q, state_d;
  logic [CW-1:0]                 count_q, count_d;
  logic [CW-1:0]                 rd_addr_q, raddr;
  logic signed [DW-1:0]          best_q, best_d;
  logic [CW-1:0]                 best_at_q, best_at_d;
  logic [swrm_pkg::STAT_W-1:0]   status_q, status_d;
  logic [DW-1:0]                 removed_q, removed_d;
  logic                          out_valid_q;
  swrm_pkg::out_item_t           out_q, out_d;
  logic                          out_load;
  logic                          in_accept;
  swrm_pkg::mem_req_t            mem_req;
  logic [DW-1:0]                 rdata;
  logic                          less;
  logic [CW-1:0]                 shift_src;
  logic [CW+swrm_pkg::ECNT_W-1:0] count_ext;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // The scan comparator: the first entry read always becomes the best.
  assign less      = (rd_addr_q == '0) || ($signed(rdata) < best_q);
  assign best_d    = less ? $signed(rdata) : best_q;
  assign best_at_d = less ? rd_addr_q : best_at_q;
  assign shift_src = best_at_d + CW'(1);

  assign out_load  = (state_q == S_LOAD) && (!out_valid_q || !out_stall_i);
  assign count_ext = {{swrm_pkg::ECNT_W{1'b0}}, count_q};

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    status_d      = status_q;
    removed_d     = removed_q;
    raddr         = '0;
    mem_req.we    = 1'b0;
    mem_req.waddr = count_q[IW-1:0];
    mem_req.wdata = in_data_i.push_value;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          status_d  = swrm_pkg::ST_OK;
          removed_d = '0;
          state_d   = S_TOP;
          case (in_data_i.req_type)
            swrm_pkg::REQ_PUSH: begin
              if (count_q == CW'(swrm_pkg::DEPTH)) begin
                status_d = swrm_pkg::ST_FULL;
              end else begin
                mem_req.we = 1'b1;
                count_d    = count_q + CW'(1);
              end
            end
            swrm_pkg::REQ_POP: begin
              if (count_q == '0) begin
                status_d = swrm_pkg::ST_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
            swrm_pkg::REQ_REMOVE_MIN: begin
              if (count_q == '0) begin
                status_d = swrm_pkg::ST_EMPTY;
              end else begin
                raddr   = '0;
                state_d = S_SCAN;
              end
            end
            default: begin
              // Unused request code: the stack is left as it is.
            end
          endcase
        end
      end
      S_SCAN: begin
        raddr = rd_addr_q + CW'(1);
        if (rd_addr_q == count_q - CW'(1)) begin
          removed_d = best_d;
          if (shift_src < count_q) begin
            raddr   = shift_src;
            state_d = S_SHIFT;
          end else begin
            count_d = count_q - CW'(1);
            state_d = S_TOP;
          end
        end
      end
      S_SHIFT: begin
        // Each entry above the minimum moves down one place.
        mem_req.we    = 1'b1;
        mem_req.waddr = IW'(rd_addr_q - CW'(1));
        mem_req.wdata = rdata;
        raddr         = rd_addr_q + CW'(1);
        if (rd_addr_q + CW'(1) >= count_q) begin
          count_d = count_q - CW'(1);
          state_d = S_TOP;
        end
      end
      S_TOP: begin
        raddr   = count_q - CW'(1);
        state_d = S_LOAD;
      end
      S_LOAD: begin
        raddr = count_q - CW'(1);
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    mem_req.raddr = raddr[IW-1:0];
  end

  always_comb begin
    out_d.status        = status_q;
    out_d.removed_value = removed_q;
    out_d.top_value     = (count_q == '0) ? '0 : rdata;
    out_d.is_empty      = (count_q == '0);
    out_d.entry_count   = count_ext[swrm_pkg::ECNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= raddr;
    status_q  <= status_d;
    removed_q <= removed_d;
    if (state_q == S_SCAN) begin
      best_q    <= best_d;
      best_at_q <= best_at_d;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  swrm_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The fill count never goes past the stack depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(swrm_pkg::DEPTH))
    else $error("fill count exceeds depth");

  // The store is written only by an accepted push or by the compaction pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> (state_q == S_SHIFT) ||
                   (in_accept && in_data_i.req_type == swrm_pkg::REQ_PUSH))
    else $error("unexpected store write");

  // A scan only runs over a non-empty stack.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (count_q != '0))
    else $error("scan on empty stack");

  // A finished result waits while the output register is full and stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD && out_valid_q && out_stall_i) |=> (state_q == S_LOAD))
    else $error("result loaded over a stalled transfer");

  // A failed request never reports a removed value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != swrm_pkg::ST_OK) |-> (out_q.removed_value == '0))
    else $error("removed value on failed request");

endmodule
